>>> hw/rtl/dbh_pkg.sv
`default_nettype none

package dbh_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_RD_PRESS = 2'd1,
    OP_RD_HOLD  = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRESSED_LEVEL = 2'd0,
    CFG_FIRST_HOLD    = 2'd1,
    CFG_REPEAT_HOLD   = 2'd2,
    CFG_HOLD_MASK     = 2'd3
  } cfg_idx_t;

  // fixed field widths
  localparam int unsigned RAW_W   = 3;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned IDX_SPAN = 1 << IDX_W;

  // reset values of the registers
  localparam logic               RST_PRESSED_LEVEL = 1'b0;
  localparam logic [TICKS_W-1:0] RST_FIRST_HOLD    = 16'd300;
  localparam logic [TICKS_W-1:0] RST_REPEAT_HOLD   = 16'd30;
  localparam logic [RAW_W-1:0]   RST_HOLD_MASK     = 3'd6;

  // per-lane configuration view
  typedef struct packed {
    logic               pressed_level;
    logic               hold_en;
    logic [TICKS_W-1:0] first_hold_ticks;
    logic [TICKS_W-1:0] repeat_hold_ticks;
  } lane_cfg_t;

  // per-lane controls for one accepted item
  typedef struct packed {
    logic tick;
    logic raw;
    logic clr_press;
    logic clr_hold;
  } lane_ctl_t;

  // per-lane status toward the merge stage
  typedef struct packed {
    logic stable_nxt;
    logic press_flag;
    logic hold_flag;
  } lane_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/dbh_lane.sv
`default_nettype none

module dbh_lane #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dbh_pkg::lane_cfg_t cfg,
  input  wire dbh_pkg::lane_ctl_t ctl,
  output dbh_pkg::lane_stat_t     stat
);

  localparam logic [31:0] RST_COUNT = 32'd300;

  logic [2:0]             hist_r, hist_nxt;
  logic                   stable_r, stable_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_dec;
  logic                   press_r, press_nxt;
  logic                   hold_r, hold_nxt;
  logic                   agree;
  logic                   smp;

  // shift in the new sample and check for three agreeing samples
  always_comb begin
    hist_nxt   = hist_r;
    stable_nxt = stable_r;
    cnt_nxt    = cnt_r;
    press_nxt  = press_r;
    hold_nxt   = hold_r;
    cnt_dec    = cnt_r - COUNT_WIDTH'(1);
    smp        = ctl.raw;
    agree      = 1'b0;
    if (ctl.tick) begin
      hist_nxt = {hist_r[1:0], ctl.raw};
      agree    = (hist_nxt == 3'b000) || (hist_nxt == 3'b111);
      if (agree) begin
        if (stable_r != smp) begin
          stable_nxt = smp;
          if (smp == cfg.pressed_level) begin
            press_nxt = 1'b1;
            cnt_nxt   = COUNT_WIDTH'(cfg.first_hold_ticks);
          end
        end else if ((smp == cfg.pressed_level) && cfg.hold_en) begin
          // steady press: count down, fire and reload at zero
          if (cnt_dec == '0) begin
            hold_nxt = 1'b1;
            cnt_nxt  = COUNT_WIDTH'(cfg.repeat_hold_ticks);
          end else begin
            cnt_nxt = cnt_dec;
          end
        end
      end
    end
    if (ctl.clr_press) begin
      press_nxt = 1'b0;
    end
    if (ctl.clr_hold) begin
      hold_nxt = 1'b0;
    end
  end

  // lane state, reset to the released level (pin high)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= {3{~dbh_pkg::RST_PRESSED_LEVEL}};
      stable_r <= ~dbh_pkg::RST_PRESSED_LEVEL;
      cnt_r    <= COUNT_WIDTH'(RST_COUNT);
      press_r  <= 1'b0;
      hold_r   <= 1'b0;
    end else begin
      hist_r   <= hist_nxt;
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
      press_r  <= press_nxt;
      hold_r   <= hold_nxt;
    end
  end

  assign stat.stable_nxt = stable_nxt;
  assign stat.press_flag = press_r;
  assign stat.hold_flag  = hold_r;

endmodule

`default_nettype wire

>>> hw/rtl/button_debounce_with_hold_repeat.sv
`default_nettype none

// Debouncer for up to NUM_BUTTONS push buttons with press and hold/repeat
// events. One lane per button runs side by side; a tick item (tuser = 0)
// samples all raw levels at once, and a query item (tuser = 1 press, 2 hold)
// reads and clears one button's sticky flag. Every item yields exactly one
// result item carrying the queried flag and the debounced levels after the
// item. One item is taken per clock unless out_tready stalls the output;
// a single output register holds the result and lets a new item in while the previous
// result is being taken. Configuration is written through cfg_wr_en /
// cfg_index / cfg_wdata and should only change while the block is idle.
module button_debounce_with_hold_repeat #(
  parameter int unsigned NUM_BUTTONS = 3,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [2:0] raw_levels, [4:3] button_index
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [0] flag_value, [3:1] stable_levels
);

  localparam int unsigned RAW_W   = dbh_pkg::RAW_W;
  localparam int unsigned IDX_W   = dbh_pkg::IDX_W;
  localparam int unsigned SPAN    = dbh_pkg::IDX_SPAN;
  localparam int unsigned TICKS_W = dbh_pkg::TICKS_W;

  // configuration registers
  logic               pressed_level_r;
  logic [TICKS_W-1:0] first_hold_r;
  logic [TICKS_W-1:0] repeat_hold_r;
  logic [RAW_W-1:0]   hold_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_level_r <= dbh_pkg::RST_PRESSED_LEVEL;
      first_hold_r    <= dbh_pkg::RST_FIRST_HOLD;
      repeat_hold_r   <= dbh_pkg::RST_REPEAT_HOLD;
      hold_mask_r     <= dbh_pkg::RST_HOLD_MASK;
    end else if (cfg_wr_en) begin
      case (dbh_pkg::cfg_idx_t'(cfg_index))
        dbh_pkg::CFG_PRESSED_LEVEL: pressed_level_r <= cfg_wdata[0];
        dbh_pkg::CFG_FIRST_HOLD:    first_hold_r    <= cfg_wdata;
        dbh_pkg::CFG_REPEAT_HOLD:   repeat_hold_r   <= cfg_wdata;
        dbh_pkg::CFG_HOLD_MASK:     hold_mask_r     <= cfg_wdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // input item decode
  logic               in_acc;
  dbh_pkg::op_t       in_op;
  logic [RAW_W-1:0]   in_raw;
  logic [IDX_W-1:0]   in_idx;
  logic               is_tick, is_rd_press, is_rd_hold;

  assign in_acc      = in_tvalid && in_tready;
  assign in_op       = dbh_pkg::op_t'(in_tuser);
  assign in_raw      = in_tdata[RAW_W-1:0];
  assign in_idx      = in_tdata[RAW_W+IDX_W-1:RAW_W];
  assign is_tick     = (in_op == dbh_pkg::OP_TICK);
  assign is_rd_press = (in_op == dbh_pkg::OP_RD_PRESS);
  assign is_rd_hold  = (in_op == dbh_pkg::OP_RD_HOLD);

  // one lane per button
  dbh_pkg::lane_stat_t stat [NUM_BUTTONS];

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_lane
    dbh_pkg::lane_cfg_t lcfg;
    dbh_pkg::lane_ctl_t lctl;

    assign lcfg.pressed_level     = pressed_level_r;
    assign lcfg.first_hold_ticks  = first_hold_r;
    assign lcfg.repeat_hold_ticks = repeat_hold_r;
    assign lctl.tick              = in_acc && is_tick;

    if (k < RAW_W) begin : g_pin
      assign lcfg.hold_en = hold_mask_r[k];
      assign lctl.raw     = in_raw[k];
    end else begin : g_nopin
      assign lcfg.hold_en = 1'b0;
      assign lctl.raw     = 1'b0;
    end

    if (k < SPAN) begin : g_query
      assign lctl.clr_press = in_acc && is_rd_press && (in_idx == IDX_W'(k));
      assign lctl.clr_hold  = in_acc && is_rd_hold && (in_idx == IDX_W'(k));
    end else begin : g_noquery
      assign lctl.clr_press = 1'b0;
      assign lctl.clr_hold  = 1'b0;
    end

    dbh_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg   (lcfg),
      .ctl   (lctl),
      .stat  (stat[k])
    );
  end

  // merge: flags by button index, levels of the first three buttons
  logic [SPAN-1:0]  press_vec;
  logic [SPAN-1:0]  hold_vec;
  logic [RAW_W-1:0] stable_vec;

  for (genvar j = 0; j < SPAN; j++) begin : g_flags
    if (j < NUM_BUTTONS) begin : g_on
      assign press_vec[j] = stat[j].press_flag;
      assign hold_vec[j]  = stat[j].hold_flag;
    end else begin : g_off
      assign press_vec[j] = 1'b0;
      assign hold_vec[j]  = 1'b0;
    end
  end

  for (genvar j = 0; j < RAW_W; j++) begin : g_levels
    if (j < NUM_BUTTONS) begin : g_on
      assign stable_vec[j] = stat[j].stable_nxt;
    end else begin : g_off
      assign stable_vec[j] = 1'b0;
    end
  end

  logic flag_sel;

  always_comb begin
    case (in_op)
      dbh_pkg::OP_RD_PRESS: flag_sel = press_vec[in_idx];
      dbh_pkg::OP_RD_HOLD:  flag_sel = hold_vec[in_idx];
      default:              flag_sel = 1'b0;
    endcase
  end

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;

  assign in_tready     = !out_valid_r || out_tready;
  assign out_valid_nxt = in_acc || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {4'b0000, stable_vec, flag_sel};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted item always shows up as a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted item produced no result");

  // a tick never reports a flag
  a_tick_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_tick) |=> !out_tdata[0])
    else $error("tick reported a flag");

  // a query leaves the debounced levels untouched
  a_query_keeps_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_tick) |=> (out_tdata[3:1] == $past(stable_vec)))
    else $error("query changed debounced levels");

  // a press query clears the flag it read
  a_press_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_rd_press) |=> !press_vec[$past(in_idx)])
    else $error("press flag not cleared by query");

endmodule

`default_nettype wire
